### rtl/cbm_pkg.sv
package cbm_pkg;

	// Request opcodes
	localparam logic [1:0] OP_WRITE    = 2'd0;
	localparam logic [1:0] OP_CPU_READ = 2'd1;
	localparam logic [1:0] OP_PPU_READ = 2'd2;

	// Classes assigned by the front end
	localparam logic [3:0] CLS_NONE       = 4'd0;
	localparam logic [3:0] CLS_CMD        = 4'd1;
	localparam logic [3:0] CLS_BANK       = 4'd2;
	localparam logic [3:0] CLS_MIRROR     = 4'd3;
	localparam logic [3:0] CLS_SRAM       = 4'd4;
	localparam logic [3:0] CLS_IRQ_LATCH  = 4'd5;
	localparam logic [3:0] CLS_IRQ_RELOAD = 4'd6;
	localparam logic [3:0] CLS_IRQ_CLEAR  = 4'd7;
	localparam logic [3:0] CLS_IRQ_EN     = 4'd8;
	localparam logic [3:0] CLS_PRG_READ   = 4'd9;
	localparam logic [3:0] CLS_CHR_READ   = 4'd10;

	// Register addresses
	localparam logic [15:0] REG_CMD        = 16'h8000;
	localparam logic [15:0] REG_BANK       = 16'h8001;
	localparam logic [15:0] REG_MIRROR     = 16'hA000;
	localparam logic [15:0] REG_SRAM       = 16'hA001;
	localparam logic [15:0] REG_IRQ_LATCH  = 16'hC000;
	localparam logic [15:0] REG_IRQ_RELOAD = 16'hC001;
	localparam logic [15:0] REG_IRQ_CLEAR  = 16'hE000;
	localparam logic [15:0] REG_IRQ_EN     = 16'hE001;

	// ROM image header length in bytes
	localparam logic [21:0] HEADER_BYTES = 22'd16;

	// Classified operation passed from front to back
	typedef struct packed {
		logic [3:0]  kind;
		logic [14:0] addr;
		logic [7:0]  data;
	} op_t;

endpackage

### rtl/cbm_req_if.sv
interface cbm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, output opcode, output address, output write_data,
		input ready);
	modport sink (input valid, input opcode, input address, input write_data,
		output ready);
endinterface

### rtl/cbm_rsp_if.sv
interface cbm_rsp_if;
	logic        valid;
	logic        ready;
	logic [21:0] rom_offset;
	logic        translated;
	logic        mirror_horizontal;
	logic        save_ram_on;
	logic [7:0]  irq_count_now;
	logic        irq_armed;

	modport source (output valid, output rom_offset, output translated,
		output mirror_horizontal, output save_ram_on, output irq_count_now,
		output irq_armed, input ready);
	modport sink (input valid, input rom_offset, input translated,
		input mirror_horizontal, input save_ram_on, input irq_count_now,
		input irq_armed, output ready);
endinterface

### rtl/cbm_front.sv
module cbm_front (
	input  logic            clk,
	input  logic            arst_n,
	cbm_req_if.sink         req,
	output logic            push,
	output cbm_pkg::op_t    push_op,
	input  logic            q_ready
);

	logic         valid_s1;
	cbm_pkg::op_t op_s1;
	cbm_pkg::op_t op_c;

	assign req.ready = !valid_s1 || q_ready;
	assign push      = valid_s1;
	assign push_op   = op_s1;

	always_comb begin
		op_c.kind = cbm_pkg::CLS_NONE;
		op_c.addr = req.address[14:0];
		op_c.data = req.write_data;
		unique case (req.opcode)
			cbm_pkg::OP_WRITE: begin
				unique case (req.address)
					cbm_pkg::REG_CMD:        op_c.kind = cbm_pkg::CLS_CMD;
					cbm_pkg::REG_BANK:       op_c.kind = cbm_pkg::CLS_BANK;
					cbm_pkg::REG_MIRROR:     op_c.kind = cbm_pkg::CLS_MIRROR;
					cbm_pkg::REG_SRAM:       op_c.kind = cbm_pkg::CLS_SRAM;
					cbm_pkg::REG_IRQ_LATCH:  op_c.kind = cbm_pkg::CLS_IRQ_LATCH;
					cbm_pkg::REG_IRQ_RELOAD: op_c.kind = cbm_pkg::CLS_IRQ_RELOAD;
					cbm_pkg::REG_IRQ_CLEAR:  op_c.kind = cbm_pkg::CLS_IRQ_CLEAR;
					cbm_pkg::REG_IRQ_EN:     op_c.kind = cbm_pkg::CLS_IRQ_EN;
					default:                 op_c.kind = cbm_pkg::CLS_NONE;
				endcase
			end
			cbm_pkg::OP_CPU_READ: begin
				if (req.address[15])
					op_c.kind = cbm_pkg::CLS_PRG_READ;
			end
			cbm_pkg::OP_PPU_READ: begin
				if (req.address[15:13] == 3'b000)
					op_c.kind = cbm_pkg::CLS_CHR_READ;
			end
			default: op_c.kind = cbm_pkg::CLS_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			op_s1 <= op_c;
	end

endmodule

### rtl/cbm_fifo.sv
module cbm_fifo #(
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cbm_pkg::op_t push_op,
	output logic         ready,
	input  logic         pop,
	output cbm_pkg::op_t pop_op,
	output logic         avail
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cbm_pkg::op_t     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;
	logic             pop_fire;

	assign ready     = (count_q != CNT_W'(DEPTH));
	assign avail     = (count_q != '0);
	assign push_fire = push && ready;
	assign pop_fire  = pop && avail;
	assign pop_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_fire)
			mem_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop_fire)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push_fire && !pop_fire)
				count_q <= count_q + 1'b1;
			else if (pop_fire && !push_fire)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop requested from empty queue");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!push_fire && !pop_fire) |=> $stable(count_q))
		else $error("occupancy moved without push or pop");

endmodule

### rtl/cbm_back.sv
module cbm_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [5:0]   cfg_data,
	input  logic         avail,
	input  cbm_pkg::op_t op,
	output logic         take,
	cbm_rsp_if.source    rsp
);

	localparam logic [2:0] CMD_CHR2K_LO = 3'd0;
	localparam logic [2:0] CMD_CHR2K_HI = 3'd1;
	localparam logic [2:0] CMD_CHR1K_0  = 3'd2;
	localparam logic [2:0] CMD_CHR1K_1  = 3'd3;
	localparam logic [2:0] CMD_CHR1K_2  = 3'd4;
	localparam logic [2:0] CMD_CHR1K_3  = 3'd5;
	localparam logic [2:0] CMD_PRG_SEL  = 3'd6;
	localparam logic [2:0] CMD_PRG_MID  = 3'd7;

	logic [5:0]  prg_banks_q;
	logic [7:0]  cmd_q;
	logic        swapped_q;
	logic        inverted_q;
	logic [7:0]  sel_prg_q;
	logic [7:0]  prg_bank_q [4];
	logic [8:0]  chr_bank_q [8];
	logic [7:0]  irq_count_q;
	logic [7:0]  irq_reload_q;
	logic        irq_on_q;
	logic        mirror_q;
	logic        save_ram_q;
	logic        out_valid_q;
	logic [21:0] rom_offset_q;
	logic        translated_q;

	logic [7:0]  twice_p;
	logic [7:0]  second_last;
	logic [7:0]  cfg_twice_p;
	logic [7:0]  cfg_second_last;
	logic [7:0]  cfg_last;
	logic [2:0]  flip;
	logic [2:0]  idx_2k;
	logic [2:0]  idx_1k;
	logic [8:0]  data_plus1;
	logic [21:0] prg_offset;
	logic [21:0] chr_offset;

	assign take = avail && (!out_valid_q || rsp.ready);

	assign twice_p         = {1'b0, prg_banks_q, 1'b0};
	assign second_last     = twice_p - 8'd2;
	assign cfg_twice_p     = {1'b0, cfg_data, 1'b0};
	assign cfg_second_last = cfg_twice_p - 8'd2;
	assign cfg_last        = cfg_twice_p - 8'd1;

	assign flip       = {inverted_q, 2'b00};
	assign idx_2k     = {1'b0, cmd_q[0], 1'b0} ^ flip;
	assign idx_1k     = (cmd_q[2:0] + 3'd2) ^ flip;
	assign data_plus1 = {1'b0, op.data} + 9'd1;

	assign prg_offset = cbm_pkg::HEADER_BYTES
		+ {1'b0, prg_bank_q[op.addr[14:13]], op.addr[12:0]};
	assign chr_offset = cbm_pkg::HEADER_BYTES + {2'b00, prg_banks_q, 14'd0}
		+ {3'b000, chr_bank_q[op.addr[12:10]], op.addr[9:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_banks_q   <= 6'd2;
			cmd_q         <= '0;
			swapped_q     <= 1'b0;
			inverted_q    <= 1'b0;
			sel_prg_q     <= '0;
			prg_bank_q[0] <= 8'd0;
			prg_bank_q[1] <= 8'd0;
			prg_bank_q[2] <= 8'd2;
			prg_bank_q[3] <= 8'd3;
			for (int i = 0; i < 8; i++)
				chr_bank_q[i] <= '0;
			irq_count_q   <= '0;
			irq_reload_q  <= '0;
			irq_on_q      <= 1'b0;
			mirror_q      <= 1'b0;
			save_ram_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				prg_banks_q   <= cfg_data;
				prg_bank_q[3] <= cfg_last;
				if (swapped_q)
					prg_bank_q[0] <= cfg_second_last;
				else
					prg_bank_q[2] <= cfg_second_last;
			end
			if (take) begin
				unique case (op.kind)
					cbm_pkg::CLS_CMD: begin
						cmd_q      <= op.data;
						inverted_q <= op.data[7];
						if (op.data[6] && !swapped_q) begin
							prg_bank_q[0] <= second_last;
							prg_bank_q[2] <= sel_prg_q;
							swapped_q     <= 1'b1;
						end else if (!op.data[6] && swapped_q) begin
							prg_bank_q[2] <= second_last;
							prg_bank_q[0] <= sel_prg_q;
							swapped_q     <= 1'b0;
						end
					end
					cbm_pkg::CLS_BANK: begin
						unique case (cmd_q[2:0]) inside
							CMD_CHR2K_LO, CMD_CHR2K_HI: begin
								chr_bank_q[idx_2k]        <= {1'b0, op.data};
								chr_bank_q[idx_2k | 3'd1] <= data_plus1;
							end
							CMD_CHR1K_0, CMD_CHR1K_1, CMD_CHR1K_2, CMD_CHR1K_3:
								chr_bank_q[idx_1k] <= {1'b0, op.data};
							CMD_PRG_SEL: begin
								sel_prg_q <= op.data;
								if (cmd_q[6])
									prg_bank_q[2] <= op.data;
								else
									prg_bank_q[0] <= op.data;
							end
							CMD_PRG_MID: prg_bank_q[1] <= op.data;
							default: ;
						endcase
					end
					cbm_pkg::CLS_MIRROR: mirror_q <= op.data[0];
					cbm_pkg::CLS_SRAM: begin
						if (op.data != 8'd0)
							save_ram_q <= 1'b1;
					end
					cbm_pkg::CLS_IRQ_LATCH: begin
						if (!irq_on_q)
							irq_count_q <= op.data;
					end
					cbm_pkg::CLS_IRQ_RELOAD: irq_reload_q <= op.data;
					cbm_pkg::CLS_IRQ_CLEAR: begin
						irq_count_q <= irq_reload_q;
						irq_on_q    <= 1'b0;
					end
					cbm_pkg::CLS_IRQ_EN: irq_on_q <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			case (op.kind)
				cbm_pkg::CLS_PRG_READ: begin
					rom_offset_q <= prg_offset;
					translated_q <= 1'b1;
				end
				cbm_pkg::CLS_CHR_READ: begin
					rom_offset_q <= chr_offset;
					translated_q <= 1'b1;
				end
				default: begin
					rom_offset_q <= '0;
					translated_q <= 1'b0;
				end
			endcase
		end
	end

	// Status fields change only at take, so they always match the beat on offer
	assign rsp.valid             = out_valid_q;
	assign rsp.rom_offset        = rom_offset_q;
	assign rsp.translated        = translated_q;
	assign rsp.mirror_horizontal = mirror_q;
	assign rsp.save_ram_on       = save_ram_q;
	assign rsp.irq_count_now     = irq_count_q;
	assign rsp.irq_armed         = irq_on_q;

	a_last_window: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> prg_bank_q[3] == $past(cfg_last))
		else $error("last program window not re-established on size write");

	a_swap_tracks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op.kind == cbm_pkg::CLS_CMD) |=> swapped_q == $past(op.data[6]))
		else $error("swap mode does not follow command bit 6");

	a_sram_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		save_ram_q |=> save_ram_q)
		else $error("save RAM enable cleared");

endmodule

### rtl/cartridge_bank_mapper.sv
// A request beat passes the front stage, the queue and then the response register.
// Throughput: one beat per cycle; the back end executes one queued operation per cycle
// whenever its response register is free or being drained.
// Reset (arst_n low, asynchronous): 2 program units, windows {0,0,2,3}, all pattern
// windows, flags and interrupt registers cleared, queue and response register empty.
module cartridge_bank_mapper #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	cbm_req_if.sink    req,
	cbm_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic [5:0] cfg_data
);

	// Front end: take the request beat, decode the register address or read
	// window and hold the classified operation in a single stage.
	logic         push;
	cbm_pkg::op_t push_op;
	logic         q_ready;

	// Queue: decouple classification from execution so either side can stall.
	logic         pop;
	cbm_pkg::op_t pop_op;
	logic         q_avail;

	cbm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.push    (push),
		.push_op (push_op),
		.q_ready (q_ready)
	);

	cbm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.ready   (q_ready),
		.pop     (pop),
		.pop_op  (pop_op),
		.avail   (q_avail)
	);

	// Back end: hold all mapper state, apply register writes, translate reads
	// through the window tables and drive the response register. Size writes
	// on the configuration port land here too and refresh the fixed windows.
	cbm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.avail    (q_avail),
		.op       (pop_op),
		.take     (pop),
		.rsp      (rsp)
	);

endmodule
